### hw/rtl/bshl_pkg.sv
// Shared types, codes and constants for the bounded sorted hit list.
`timescale 1ns / 1ps
`default_nettype none
package bshl_pkg;

  localparam int MAX_RECORDS_DEF = 16;
  localparam int KEY_W   = 32;
  localparam int TAG_W   = 32;
  localparam int RIDX_W  = 4;
  localparam int POS_W   = 4;
  localparam int CNT_O_W = 5;
  localparam int CAP_W   = 5;
  localparam int REC_W   = KEY_W + 1 + TAG_W;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 80;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } bshl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHKLAST,
    ST_CMP,
    ST_PLACE,
    ST_RDATA,
    ST_DONE
  } bshl_state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             uv;
    logic [KEY_W-1:0] distance;
  } bshl_rec_t;

  typedef struct packed {
    bshl_cmd_t         cmd;
    bshl_rec_t         rec;
    logic [RIDX_W-1:0] ridx;
  } bshl_req_t;

  typedef struct packed {
    logic               inserted;
    logic [POS_W-1:0]   position;
    logic [CNT_O_W-1:0] count;
    logic               read_valid;
    bshl_rec_t          rec;
  } bshl_result_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } bshl_cmp_t;

endpackage
`default_nettype wire

### hw/rtl/bounded_sorted_hit_list_top.sv
// Bounded sorted hit list: capacity register, stream ports and output register.
// An insert into a full list first checks the last record and drops a hit that is not below it;
// otherwise the insert walks from the tail towards the head, moving each record the hit goes
// ahead of one slot back. One command at a time: a new command is taken only once the result
// of the last one has gone into the output register.
// Synchronous reset empties the list and sets capacity to 16 (or MAX_RECORDS if smaller); records are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_sorted_hit_list_top
  import bshl_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // hit_distance[31:0], uv_given[32], object_tag[64:33], read_index[68:65]
  input  wire logic [IN_W-1:0]  s_tdata,
  // command[1:0]
  input  wire logic [1:0]       s_tuser,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // inserted[0], insert_position[4:1], entry_count[9:5], read_valid[10],
  // read_distance[42:11], read_uv_given[43], read_object_tag[75:44]
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  logic [CNT_W-1:0] capacity, cap_clamped;
  bshl_req_t        req;
  bshl_result_t     seq_res, out_res;
  logic             seq_ready, seq_res_valid, res_take, out_valid;

  // zero reads as one, anything above the record store saturates
  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (32'(cfg_data) > MAX_RECORDS) begin
      cap_clamped = CNT_W'(MAX_RECORDS);
    end else begin
      cap_clamped = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= (MAX_RECORDS < 16) ? CNT_W'(MAX_RECORDS) : CNT_W'(16);
    end else if (cfg_we) begin
      capacity <= cap_clamped;
    end
  end

  always_comb begin
    req.cmd          = bshl_cmd_t'(s_tuser);
    req.rec.distance = s_tdata[KEY_W-1:0];
    req.rec.uv       = s_tdata[KEY_W];
    req.rec.tag      = s_tdata[KEY_W+TAG_W:KEY_W+1];
    req.ridx         = s_tdata[REC_W+RIDX_W-1:REC_W];
  end

  assign s_tready = seq_ready;
  assign res_take = seq_res_valid && (!out_valid || m_tready);

  bshl_seq #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid && seq_ready),
    .req      (req),
    .cap      (capacity),
    .cfg_we   (cfg_we),
    .cfg_cap  (cap_clamped),
    .ready    (seq_ready),
    .res_valid(seq_res_valid),
    .res_take (res_take),
    .result   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= seq_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_res.rec.tag, out_res.rec.uv, out_res.rec.distance,
                     out_res.read_valid, out_res.count, out_res.position,
                     out_res.inserted};

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in progress");

  a_insert_or_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.inserted && out_res.read_valid))
    else $error("result marks both an insert and a read");

  a_position_in_list: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.inserted |-> CNT_O_W'(out_res.position) < out_res.count)
    else $error("insert position beyond entry count");

  a_capacity_nonzero: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> capacity != '0)
    else $error("capacity register holds zero");
`endif

endmodule
`default_nettype wire

### hw/rtl/bshl_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bshl_ram
  import bshl_pkg::*;
#(
  parameter int WIDTH = REC_W,
  parameter int DEPTH = MAX_RECORDS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/bshl_cmp.sv
// Shared key comparator: stored key against the key of the hit being placed.
`timescale 1ns / 1ps
`default_nettype none
module bshl_cmp
  import bshl_pkg::*;
(
  input  wire logic [KEY_W-1:0] stored_key,
  input  wire logic [KEY_W-1:0] new_key,
  output bshl_cmp_t             result
);

  always_comb begin
    result.gt = stored_key > new_key;
    result.eq = stored_key == new_key;
  end

endmodule
`default_nettype wire

### hw/rtl/bshl_seq.sv
// Command sequencer: walks the record RAM one entry per cycle through the comparator.
`timescale 1ns / 1ps
`default_nettype none
module bshl_seq
  import bshl_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  localparam int IDX_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CNT_W      = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bshl_req_t        req,
  input  wire logic [CNT_W-1:0] cap,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_cap,
  output logic                  ready,
  output logic                  res_valid,
  input  wire logic             res_take,
  output bshl_result_t          result
);

  bshl_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] pos, pos_next;
  bshl_req_t        cur, cur_next;
  bshl_result_t     res, res_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  bshl_rec_t        ram_wdata, ram_rdata;
  bshl_cmp_t        cmp;
  logic             goes_after;

  bshl_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bshl_cmp u_cmp (
    .stored_key(ram_rdata.distance),
    .new_key   (cur.rec.distance),
    .result    (cmp)
  );

  // stored record goes behind the new hit: larger key, or equal key without uv
  assign goes_after = cmp.gt || (cmp.eq && !ram_rdata.uv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      // clamp the fill on a capacity write, dropping the tail
      if (cfg_we && count > cfg_cap) begin
        count <= cfg_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    res <= res_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    cur_next   = cur;
    res_next   = res;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = cur.rec;
    ram_raddr  = '0;
    ready      = 1'b0;
    res_valid  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          cur_next   = req;
          state_next = ST_START;
        end
      end

      ST_START: begin
        res_next = '0;
        state_next = ST_DONE;
        unique case (cur.cmd)
          CMD_INSERT: begin
            if (count == '0) begin
              ram_we            = 1'b1;
              ram_waddr         = '0;
              count_next        = CNT_W'(1);
              res_next.inserted = 1'b1;
            end else if (count >= cap) begin
              pos_next   = IDX_W'(cap - CNT_W'(1));
              ram_raddr  = IDX_W'(cap - CNT_W'(1));
              state_next = ST_CHKLAST;
            end else begin
              pos_next   = IDX_W'(count);
              ram_raddr  = IDX_W'(count - CNT_W'(1));
              count_next = count + CNT_W'(1);
              state_next = ST_CMP;
            end
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          CMD_READ: begin
            if (32'(cur.ridx) < 32'(count) && 32'(cur.ridx) < MAX_RECORDS) begin
              ram_raddr  = IDX_W'(cur.ridx);
              state_next = ST_RDATA;
            end
          end
          default: begin
          end
        endcase
      end

      ST_CHKLAST: begin
        if (!cmp.gt) begin
          // key not below the last record: drop
          state_next = ST_DONE;
        end else if (pos == '0) begin
          ram_we            = 1'b1;
          res_next.inserted = 1'b1;
          res_next.position = '0;
          state_next        = ST_DONE;
        end else begin
          ram_raddr  = pos - IDX_W'(1);
          state_next = ST_CMP;
        end
      end

      ST_CMP: begin
        if (goes_after) begin
          // move the earlier record one slot back and advance towards the head
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_next  = pos - IDX_W'(1);
          if (pos == IDX_W'(1)) begin
            state_next = ST_PLACE;
          end else begin
            ram_raddr = pos - IDX_W'(2);
          end
        end else begin
          ram_we            = 1'b1;
          res_next.inserted = 1'b1;
          res_next.position = POS_W'(pos);
          state_next        = ST_DONE;
        end
      end

      ST_PLACE: begin
        ram_we            = 1'b1;
        res_next.inserted = 1'b1;
        res_next.position = POS_W'(pos);
        state_next        = ST_DONE;
      end

      ST_RDATA: begin
        res_next.read_valid = 1'b1;
        res_next.rec        = ram_rdata;
        state_next          = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result       = res;
    result.count = CNT_O_W'(count);
  end

endmodule
`default_nettype wire

### tb/sv/bounded_sorted_hit_list_top_tb.sv
// Self-checking testbench for the bounded sorted hit list stream block.
`timescale 1ns / 1ps
`default_nettype none
module bounded_sorted_hit_list_top_tb
  import bshl_pkg::*;
;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic        inserted;
    logic [3:0]  position;
    logic [4:0]  count;
    logic        read_valid;
    logic [31:0] distance;
    logic        uv;
    logic [31:0] tag;
  } hit_result_t;

  logic             clk;
  logic             rst;
  logic [IN_W-1:0]  s_tdata;
  logic [1:0]       s_tuser;
  logic             s_tvalid;
  logic             s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  // shadow copy of the list
  logic [31:0] key_mem [MAX_RECORDS_DEF];
  logic        uv_mem  [MAX_RECORDS_DEF];
  logic [31:0] tag_mem [MAX_RECORDS_DEF];
  int unsigned list_len;
  int unsigned list_cap;

  hit_result_t pending_results [$];
  int          err_count;
  bit          gaps_on;

  bounded_sorted_hit_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the result of one accepted command and advance the shadow list.
  task automatic predict_hit_list(input bshl_cmd_t op, input logic [31:0] key,
                                  input logic uv, input logic [31:0] tag,
                                  input logic [3:0] idx);
    hit_result_t res;
    int          slot;
    bit          keep;
    res = '{default: '0};
    keep = 1'b1;
    case (op)
      CMD_INSERT: begin
        if (list_len == 0) begin
          slot = 0;
          list_len = 1;
        end else if (list_len >= list_cap) begin
          slot = int'(list_cap) - 1;
          keep = key < key_mem[slot];
        end else begin
          slot = int'(list_len);
          list_len++;
        end
        if (keep) begin
          // ripple ahead of larger keys and of equal keys without uv
          while (slot > 0 && (key_mem[slot-1] > key ||
                 (key_mem[slot-1] == key && !uv_mem[slot-1]))) begin
            key_mem[slot] = key_mem[slot-1];
            uv_mem[slot]  = uv_mem[slot-1];
            tag_mem[slot] = tag_mem[slot-1];
            slot--;
          end
          key_mem[slot] = key;
          uv_mem[slot]  = uv;
          tag_mem[slot] = tag;
          res.inserted = 1'b1;
          res.position = 4'(slot);
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_READ: begin
        if (idx < list_len) begin
          res.read_valid = 1'b1;
          res.distance = key_mem[idx];
          res.uv       = uv_mem[idx];
          res.tag      = tag_mem[idx];
        end
      end
      default: ;
    endcase
    res.count = 5'(list_len);
    pending_results.push_back(res);
  endtask

  task automatic send_command(input bshl_cmd_t op, input logic [31:0] key,
                              input logic uv, input logic [31:0] tag,
                              input logic [3:0] idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, idx, tag, uv, key};
    do @(posedge clk); while (!s_tready);
    predict_hit_list(op, key, uv, tag, idx);
  endtask

  // Write the capacity register once every outstanding result has drained.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    list_cap = (value == 0) ? 1 : (value > MAX_RECORDS_DEF) ? MAX_RECORDS_DEF : value;
    if (list_len > list_cap) list_len = list_cap;
  endtask

  // Favour a small key set so that ties and drops are frequent.
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 7) * 32'h0001_0000;
    if (sel == 5) return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return $urandom();
  endfunction

  task automatic send_random_command();
    int unsigned roll;
    bshl_cmd_t   op;
    logic        uv;
    logic [3:0]  idx;
    roll = $urandom_range(0, 99);
    if (roll < 55) op = CMD_INSERT;
    else if (roll < 90) op = CMD_READ;
    else if (roll < 97) op = CMD_NOP;
    else op = CMD_CLEAR;
    uv  = 1'($urandom());
    idx = 4'($urandom());
    send_command(op, pick_key(), uv, $urandom(), idx);
  endtask

  task automatic test_order_and_ties();
    send_command(CMD_READ, 32'h0, 1'b0, 32'h0, 4'd0);
    send_command(CMD_INSERT, 32'h0005_0000, 1'b0, 32'hA, 4'd0);
    send_command(CMD_INSERT, 32'h0005_0000, 1'b0, 32'hB, 4'd0);
    send_command(CMD_INSERT, 32'h0005_0000, 1'b1, 32'hC, 4'd0);
    send_command(CMD_INSERT, 32'h0005_0000, 1'b0, 32'hD, 4'd0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'hF);
    send_command(CMD_INSERT, 32'h0000_0000, 1'b0, 32'h0, 4'd0);
    for (int i = 0; i < 6; i++) send_command(CMD_READ, $urandom(), 1'b1, $urandom(), 4'(i));
    send_command(CMD_READ, 32'h0, 1'b0, 32'h0, 4'd15);
    send_command(CMD_NOP, $urandom(), 1'b1, $urandom(), 4'd3);
    send_command(CMD_CLEAR, 32'h0, 1'b0, 32'h0, 4'd0);
  endtask

  task automatic test_capacity_edges();
    set_capacity(5'd0);
    send_command(CMD_INSERT, 32'h000A_0000, 1'b0, 32'h11, 4'd0);
    send_command(CMD_INSERT, 32'h000A_0000, 1'b1, 32'h12, 4'd0);
    send_command(CMD_INSERT, 32'h0014_0000, 1'b0, 32'h13, 4'd0);
    send_command(CMD_INSERT, 32'h0003_0000, 1'b1, 32'h14, 4'd0);
    set_capacity(5'd31);
    send_command(CMD_INSERT, 32'h0001_0000, 1'b0, 32'h15, 4'd0);
    send_command(CMD_INSERT, 32'h0002_0000, 1'b1, 32'h16, 4'd0);
    // shrinking drops the tail
    set_capacity(5'd2);
    send_command(CMD_READ, 32'h0, 1'b0, 32'h0, 4'd1);
    send_command(CMD_READ, 32'h0, 1'b0, 32'h0, 4'd2);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [10] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd2,
                                    5'd17, 5'd9, 5'd0, 5'd12, 5'd3};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      repeat (150) send_random_command();
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_capacity(5'd16);
    repeat (200) send_random_command();
  endtask

  // Receiver side: random stall bursts while gaps are enabled.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns %s: expected %h actual %h", $time, what, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    hit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns unexpected result: expected none actual %h", $time, m_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("inserted", want.inserted, m_tdata[0]);
        check_field("insert_position", want.position, m_tdata[4:1]);
        check_field("entry_count", want.count, m_tdata[9:5]);
        check_field("read_valid", want.read_valid, m_tdata[10]);
        check_field("read_distance", want.distance, m_tdata[42:11]);
        check_field("read_uv_given", want.uv, m_tdata[43]);
        check_field("read_object_tag", want.tag, m_tdata[75:44]);
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either side.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    err_count = 0;
    gaps_on  = 1'b1;
    list_len = 0;
    list_cap = MAX_RECORDS_DEF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_order_and_ties();
    test_capacity_edges();
    test_random_traffic();
    test_back_to_back();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
